@@ design/psrw_pkg.sv @@
// Package for the patch-sum ratio window weights block.
// Types, constants and register indexes shared by the design files other than psrw_ram.
package psrw_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int MAX_WIN_RADIUS = 3;
   localparam int MAX_PATCH_RADIUS = 3;
   localparam int PIXEL_BITS = 16;

   localparam int ROW_BITS = $clog2(MAX_ROWS);
   localparam int COL_BITS = $clog2(MAX_COLS);
   localparam int ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int IDX_BITS = 12;
   // worst-case patch sum: (2*pr+1)^2 pixels
   localparam int SUM_BITS = PIXEL_BITS + 6;
   localparam int QUO_BITS = 32;
   localparam int CSR_DATA_BITS = 7;
   localparam int CSR_ADDR_BITS = 2;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_NUM_ROWS = 2'd0,
      CSR_NUM_COLS = 2'd1,
      CSR_WIN_RADIUS = 2'd2,
      CSR_PATCH_RADIUS = 2'd3
   } csr_index_type;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic        op;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [15:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic [11:0] center_index;
      logic [11:0] neighbor_index;
      logic [31:0] ratio;
      logic        div_zero;
      logic        last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture request
      logic wr_pixel;    // write pixel to store
      logic patch_init;  // start patch sum for current target
      logic patch_step;  // issue next patch read
      logic patch_acc;   // not driven or used; accumulation follows patch_step
      logic save_center; // latch center sum
      logic div_start;
      logic emit;
      logic win_init;
      logic win_next;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic in_image;   // query center inside image
      logic patch_done; // last patch address issued
      logic nb_valid;   // current window position in image
      logic win_done;   // current position is last of window
      logic div_done;
      logic is_query;
   } sts_type;

endpackage

@@ design/psrw_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module psrw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

@@ design/psrw_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// Depends on psrw_pkg.
module psrw_div
   import psrw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SUM_BITS-1:0] dividend,
   input  logic [SUM_BITS-1:0] divisor,
   output logic                done,
   output logic [QUO_BITS-1:0] quotient,
   output logic                div_zero
);
   localparam int NUM_BITS = SUM_BITS + 16;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [SUM_BITS:0]   rem_ff, rem_in;
   logic [SUM_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   logic [SUM_BITS:0]   trial;
   logic [SUM_BITS+1:0] diff;

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[SUM_BITS-1:0], num_ff[NUM_BITS-1]};
      diff = {1'b0, trial} - {2'b00, den_ff};
      if (start) begin
         num_in = {dividend, 16'h0000};
         rem_in = '0;
         den_in = divisor;
         cnt_in = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[SUM_BITS+1]) begin
            rem_in = diff[SUM_BITS:0];
            num_in = {num_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign div_zero = (den_ff == '0);
   always_comb begin
      if (den_ff == '0 || num_ff[NUM_BITS-1:QUO_BITS] != '0) quotient = '1;
      else quotient = num_ff[QUO_BITS-1:0];
   end
endmodule

@@ design/psrw_datapath.sv @@
// Datapath: configuration registers, frame store, patch address walk,
// sum accumulators, window walk, divider and result register.
// Depends on psrw_pkg, psrw_ram, psrw_div.
module psrw_datapath
   import psrw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  req_type                  req_data,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  ctl_type                  ctl,
   output sts_type                  sts,
   output rsp_type                  rsp_data
);
   logic [6:0] num_rows_ff, num_cols_ff;
   logic [1:0] win_rad_ff, patch_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= 7'd64;
         num_cols_ff <= 7'd64;
         win_rad_ff <= 2'd1;
         patch_rad_ff <= 2'd1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_NUM_ROWS: num_rows_ff <= csr_wdata;
            CSR_NUM_COLS: num_cols_ff <= csr_wdata;
            CSR_WIN_RADIUS: win_rad_ff <= csr_wdata[1:0];
            CSR_PATCH_RADIUS: patch_rad_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // clamped dimensions, signed 8-bit
   logic signed [7:0] m, n, wr, pr;
   always_comb begin
      m = (num_rows_ff == 0) ? 8'sd1 : (num_rows_ff > 7'(MAX_ROWS)) ? 8'(MAX_ROWS)
          : 8'(num_rows_ff);
      n = (num_cols_ff == 0) ? 8'sd1 : (num_cols_ff > 7'(MAX_COLS)) ? 8'(MAX_COLS)
          : 8'(num_cols_ff);
      wr = 8'(win_rad_ff);
      pr = 8'(patch_rad_ff);
   end

   req_type req_ff;
   logic signed [7:0] wdr_ff, wdc_ff, pdr_ff, pdc_ff;
   logic signed [7:0] tr, tc, rr, cc, rr_cl, cc_cl;
   logic [SUM_BITS-1:0] acc_ff, csum_ff;
   logic acc_pend_ff;
   logic [11:0] cidx_ff, nidx_ff;
   logic [ADDR_BITS-1:0] ram_addr;
   logic [PIXEL_BITS-1:0] ram_rdata;
   rsp_type rsp_ff;
   logic [QUO_BITS-1:0] quo;
   logic div_zero, div_done;
   logic last_pos;

   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req_data;
   end

   // target of patch: the center while window offsets are still zero
   assign tr = 8'(req_ff.row) + wdr_ff;
   assign tc = 8'(req_ff.col) + wdc_ff;
   assign rr = tr + pdr_ff;
   assign cc = tc + pdc_ff;
   assign rr_cl = (rr < 0) ? 8'sd0 : (rr > m - 8'sd1) ? m - 8'sd1 : rr;
   assign cc_cl = (cc < 0) ? 8'sd0 : (cc > n - 8'sd1) ? n - 8'sd1 : cc;

   always_comb begin
      if (ctl.wr_pixel) ram_addr = {req_ff.col, req_ff.row};
      else ram_addr = {cc_cl[COL_BITS-1:0], rr_cl[ROW_BITS-1:0]};
   end

   psrw_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .we(ctl.wr_pixel), .addr(ram_addr),
      .wdata(req_ff.pixel_value), .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         // window offsets stay zero through the center sum
         wdr_ff <= '0;
         wdc_ff <= '0;
      end else if (ctl.win_init) begin
         wdr_ff <= -wr;
         wdc_ff <= -wr;
      end else if (ctl.win_next) begin
         if (wdr_ff == wr) begin
            wdr_ff <= -wr;
            wdc_ff <= wdc_ff + 8'sd1;
         end else wdr_ff <= wdr_ff + 8'sd1;
      end
      if (ctl.patch_init) begin
         pdr_ff <= -pr;
         pdc_ff <= -pr;
      end else if (ctl.patch_step) begin
         if (pdc_ff == pr) begin
            pdc_ff <= -pr;
            pdr_ff <= pdr_ff + 8'sd1;
         end else pdc_ff <= pdc_ff + 8'sd1;
      end
      acc_pend_ff <= ctl.patch_step;
      if (ctl.patch_init) acc_ff <= '0;
      else if (acc_pend_ff) acc_ff <= acc_ff + SUM_BITS'(ram_rdata);
      if (ctl.save_center) begin
         csum_ff <= acc_ff;
         cidx_ff <= 12'(12'(req_ff.col) * 12'(m) + 12'(req_ff.row));
      end
      if (ctl.div_start) nidx_ff <= 12'(12'(tc) * 12'(m) + 12'(tr));
      if (ctl.emit) begin
         rsp_ff.center_index <= cidx_ff;
         rsp_ff.neighbor_index <= nidx_ff;
         rsp_ff.ratio <= quo;
         rsp_ff.div_zero <= div_zero;
         rsp_ff.last <= last_pos;
      end
   end

   psrw_div u_div (
      .clock(clock), .reset(reset), .start(ctl.div_start),
      .dividend(csum_ff), .divisor(acc_ff),
      .done(div_done), .quotient(quo), .div_zero(div_zero)
   );

   // last in-image window position: no later valid position remains
   logic signed [7:0] last_c, last_r;
   assign last_c = (8'(req_ff.col) + wr > n - 8'sd1) ? n - 8'sd1 : 8'(req_ff.col) + wr;
   assign last_r = (8'(req_ff.row) + wr > m - 8'sd1) ? m - 8'sd1 : 8'(req_ff.row) + wr;
   assign last_pos = (tc == last_c) && (tr == last_r);

   always_comb begin
      sts.in_image = (8'(req_ff.row) < m) && (8'(req_ff.col) < n);
      sts.patch_done = (pdr_ff == pr) && (pdc_ff == pr);
      sts.nb_valid = (tr >= 0) && (tr < m) && (tc >= 0) && (tc < n);
      sts.win_done = (wdr_ff == wr) && (wdc_ff == wr);
      sts.div_done = div_done;
      sts.is_query = (req_ff.op == OP_QUERY);
   end

   assign rsp_data = rsp_ff;
endmodule

@@ design/psrw_ctrl.sv @@
// Controller state machine sequencing writes, patch sums and divisions.
// Depends on psrw_pkg.
module psrw_ctrl
   import psrw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    busy,
   output logic    rsp_valid
);
   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_CSUM, S_CWAIT, S_CDRAIN, S_WCHK,
      S_NSUM, S_NWAIT, S_NDRAIN, S_DIV, S_EMIT, S_NEXT
   } state_type;

   state_type state_ff;
   logic valid_ff;

   always_comb begin
      ctl = '0;
      case (state_ff)
         S_IDLE: ctl.load = start;
         S_DECODE: begin
            ctl.wr_pixel = !sts.is_query;
            ctl.patch_init = 1'b1;
         end
         S_CSUM, S_NSUM: ctl.patch_step = 1'b1;
         S_CDRAIN: begin
            ctl.save_center = 1'b1;
            ctl.win_init = 1'b1;
         end
         S_WCHK: ctl.patch_init = 1'b1;
         S_NDRAIN: ctl.div_start = 1'b1;
         S_EMIT: ctl.emit = 1'b1;
         S_NEXT: ctl.win_next = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) state_ff <= S_DECODE;
            S_DECODE: begin
               if (!sts.is_query || !sts.in_image) state_ff <= S_IDLE;
               else state_ff <= S_CSUM;
            end
            S_CSUM: if (sts.patch_done) state_ff <= S_CWAIT;
            S_CWAIT: state_ff <= S_CDRAIN;
            S_CDRAIN: state_ff <= S_WCHK;
            S_WCHK: begin
               if (sts.nb_valid) state_ff <= S_NSUM;
               else if (sts.win_done) state_ff <= S_IDLE;
               else state_ff <= S_NEXT;
            end
            S_NSUM: if (sts.patch_done) state_ff <= S_NWAIT;
            S_NWAIT: state_ff <= S_NDRAIN;
            S_NDRAIN: state_ff <= S_DIV;
            S_DIV: if (sts.div_done) state_ff <= S_EMIT;
            S_EMIT: begin
               valid_ff <= 1'b1;
               if (sts.win_done) state_ff <= S_IDLE;
               else state_ff <= S_NEXT;
            end
            S_NEXT: state_ff <= S_WCHK;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
endmodule

@@ design/patch_sum_ratio_window_weights_unit.sv @@
// Channel  | ports                          | handshake
// request  | req_data, start                | taken when start && !busy
// result   | rsp_data, rsp_valid            | one-cycle strobe, no backpressure
// config   | csr_we, csr_addr, csr_wdata    | written on any edge with csr_we
// A write stores its pixel in the decode state. A query sums the center patch,
// then for each in-image neighbor sums its patch and divides; out-of-image
// window positions are skipped. The query rate is bound by the single frame-store
// read port and the bit-serial divider.
// Reset is synchronous active high; the frame store is not cleared.
// Top level; depends on psrw_pkg, psrw_ctrl, psrw_datapath.
module patch_sum_ratio_window_weights_unit
   import psrw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);
   ctl_type ctl;
   sts_type sts;

   psrw_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts),
      .ctl(ctl), .busy(busy), .rsp_valid(rsp_valid)
   );

   psrw_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .ctl(ctl), .sts(sts), .rsp_data(rsp_data)
   );
endmodule

@@ design/psrw_checker.sv @@
// Port-level checker for the top level, attached by bind.
// Depends on psrw_pkg.
module psrw_checker
   import psrw_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("start not taken");
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy || $past(busy)) else $error("result while idle");
   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.div_zero |-> rsp_data.ratio == 32'hFFFFFFFF)
      else $error("zero divisor not saturated");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back results");
endmodule

bind patch_sum_ratio_window_weights_unit psrw_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);
